// ===== src/kfc_pkg.sv =====
// Shared types, constants and register indexes of the kinematic feasibility cost block.
`default_nettype none
package kfc_pkg;
   localparam int unsigned MaxPointsDefault = 1024;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_ACCEL = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_INV_INTERVAL_SQ = 2'd2;

   localparam logic [31:0] InvIntervalSqReset = 32'h0001_0000;
   localparam logic [62:0] Sat63 = {63{1'b1}};

   typedef struct packed {
      logic [31:0] vmag;
      logic vneg;
      logic [33:0] amag;
      logic aneg;
   } axis_diff_type;

   typedef struct packed {
      axis_diff_type [2:0] axis;
      logic [1:0] fill;
      logic fin;
      logic [9:0] idx0;
      logic [9:0] idx1;
      logic [9:0] idx2;
   } point_entry_type;

   typedef struct packed {
      logic start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic [62:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic [31:0] max_speed;
      logic [31:0] max_accel;
      logic [31:0] inv_interval_sq;
   } csr_type;
endpackage
`default_nettype wire

// ===== src/kfc_mul.sv =====
// Multi-cycle saturating Q16.16 multiplier built from four 32x32 partial products.
`default_nettype none
module kfc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  kfc_pkg::mul_req_type req,
   output kfc_pkg::mul_rsp_type rsp
);
   import kfc_pkg::*;

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  x, y;
   logic [127:0] shifted;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            x = a_ff[31:0];
            y = b_ff[31:0];
         end
         2'd1: begin
            x = a_ff[31:0];
            y = b_ff[63:32];
         end
         2'd2: begin
            x = a_ff[63:32];
            y = b_ff[31:0];
         end
         default: begin
            x = a_ff[63:32];
            y = b_ff[63:32];
         end
      endcase
      case (sh_ff)
         2'd0:    shifted = {64'b0, prod_ff};
         2'd1:    shifted = {32'b0, prod_ff, 32'b0};
         2'd2:    shifted = {32'b0, prod_ff, 32'b0};
         default: shifted = {prod_ff, 64'b0};
      endcase
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      sh_in = sh_ff;
      acc_in = acc_ff;
      if (req.start) begin
         a_in = req.op_a;
         b_in = req.op_b;
         cnt_in = '0;
         busy_in = 1'b1;
         acc_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            prod_in = {32'b0, x} * {32'b0, y};
            sh_in = cnt_ff[1:0];
         end
         if (cnt_ff != 3'd0) begin
            acc_in = acc_ff + shifted;
         end
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = (|acc_ff[127:79]) ? Sat63 : acc_ff[78:16];
endmodule
`default_nettype wire

// ===== src/kfc_front.sv =====
// Front end: accepts control points, forms differences and indexes, pushes words to the queue.
`default_nettype none
module kfc_front #(
   parameter int unsigned MAX_POINTS = kfc_pkg::MaxPointsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_pos_x,
   input  logic signed [31:0]       req_pos_y,
   input  logic signed [31:0]       req_pos_z,
   input  logic                     req_final_point,
   output logic                     push,
   output kfc_pkg::point_entry_type push_entry,
   input  logic                     full
);
   import kfc_pkg::*;

   localparam int unsigned CntWidth = $clog2(MAX_POINTS);

   logic signed [31:0] prev_ff [3][2];
   logic signed [31:0] prev_in [3][2];
   logic signed [31:0] cur [3];
   logic signed [32:0] vel [3];
   logic signed [34:0] acc [3];
   logic [1:0]          fill_ff, fill_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [31:0]         n32, m32, idx0, idx1;

   assign cur[0] = req_pos_x;
   assign cur[1] = req_pos_y;
   assign cur[2] = req_pos_z;

   assign req_stall = full;
   assign push = req_valid && !full;

   assign n32 = 32'(cnt_ff);
   assign m32 = 32'(MAX_POINTS);
   assign idx0 = (n32 >= 32'd2) ? (n32 - 32'd2) : (n32 + m32 - 32'd2);
   assign idx1 = (n32 >= 32'd1) ? (n32 - 32'd1) : (m32 - 32'd1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel[i] = 33'(cur[i]) - 33'(prev_ff[i][1]);
         acc[i] = 35'(cur[i]) - (35'(prev_ff[i][1]) <<< 1) + 35'(prev_ff[i][0]);
         push_entry.axis[i].vneg = vel[i][32];
         push_entry.axis[i].vmag = vel[i][32] ? 32'(-vel[i]) : 32'(vel[i]);
         push_entry.axis[i].aneg = acc[i][34];
         push_entry.axis[i].amag = acc[i][34] ? 34'(-acc[i]) : 34'(acc[i]);
      end
      push_entry.fill = fill_ff;
      push_entry.fin = req_final_point;
      push_entry.idx0 = idx0[9:0];
      push_entry.idx1 = idx1[9:0];
      push_entry.idx2 = n32[9:0];
   end

   always_comb begin
      prev_in = prev_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      if (push) begin
         if (req_final_point) begin
            for (int i = 0; i < 3; i++) begin
               prev_in[i][0] = '0;
               prev_in[i][1] = '0;
            end
            fill_in = '0;
            cnt_in = '0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               prev_in[i][0] = prev_ff[i][1];
               prev_in[i][1] = cur[i];
            end
            if (fill_ff != 2'd2) begin
               fill_in = fill_ff + 2'd1;
            end
            cnt_in = (n32 == m32 - 32'd1) ? '0 : cnt_ff + CntWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            prev_ff[i][0] <= '0;
            prev_ff[i][1] <= '0;
         end
         fill_ff <= '0;
         cnt_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/kfc_queue.sv =====
// Short queue of point words between the front end and the back end.
`default_nettype none
module kfc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  kfc_pkg::point_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output kfc_pkg::point_entry_type pop_entry,
   output logic                     empty
);
   import kfc_pkg::*;

   localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   point_entry_type     mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrWidth:0]   count_ff, count_in;

   assign full = (count_ff == (PtrWidth+1)'(QueueDepth));
   assign empty = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PtrWidth+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PtrWidth+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

// ===== src/kfc_back.sv =====
// Back end: sequences penalty terms through the shared multiplier and emits gradient words.
`default_nettype none
module kfc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  kfc_pkg::point_entry_type q_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  kfc_pkg::csr_type         csr,
   output kfc_pkg::mul_req_type     mul_req,
   input  kfc_pkg::mul_rsp_type     mul_rsp,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [9:0]               rsp_point_index,
   output logic signed [47:0]       rsp_grad_x,
   output logic signed [47:0]       rsp_grad_y,
   output logic signed [47:0]       rsp_grad_z,
   output logic [62:0]              rsp_total_cost,
   output logic                     rsp_last_result
);
   import kfc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ISSUE = 5'b00010,
      S_WAIT  = 5'b00100,
      S_LOAD  = 5'b01000,
      S_SEND  = 5'b10000
   } state_type;

   typedef enum logic [13:0] {
      STEP_V_MM   = 14'b00000000000001,
      STEP_V_MI   = 14'b00000000000010,
      STEP_V_LIM  = 14'b00000000000100,
      STEP_V_COST = 14'b00000000001000,
      STEP_V_T    = 14'b00000000010000,
      STEP_V_G    = 14'b00000000100000,
      STEP_A_INV4 = 14'b00000001000000,
      STEP_A_MM   = 14'b00000010000000,
      STEP_A_MI   = 14'b00000100000000,
      STEP_A_LIM  = 14'b00001000000000,
      STEP_A_COST = 14'b00010000000000,
      STEP_A_T    = 14'b00100000000000,
      STEP_A_G    = 14'b01000000000000,
      STEP_A_G2   = 14'b10000000000000
   } step_type;

   localparam logic signed [49:0] GMax = 50'sh7FFF_FFFF_FFFF;
   localparam logic signed [49:0] GMin = -50'sh8000_0000_0000;
   localparam logic [48:0] MagCap = 49'h1_0000_0000_0000;

   function automatic logic [62:0] sat4(input logic [62:0] x);
      return (x[62:61] != 2'b00) ? Sat63 : {x[60:0], 2'b00};
   endfunction

   function automatic logic [62:0] sat2(input logic [62:0] x);
      return x[62] ? Sat63 : {x[61:0], 1'b0};
   endfunction

   function automatic logic [62:0] add_cost(input logic [62:0] c, input logic [62:0] x);
      logic [63:0] s;
      s = {1'b0, c} + {1'b0, x};
      return s[63] ? Sat63 : s[62:0];
   endfunction

   function automatic logic signed [47:0] add_grad(input logic signed [47:0] g,
                                                   input logic neg, input logic [62:0] mag);
      logic [48:0]        m;
      logic signed [49:0] d;
      m = (mag > 63'(MagCap)) ? MagCap : mag[48:0];
      d = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      d = d + 50'(g);
      if (d > GMax) begin
         d = GMax;
      end else if (d < GMin) begin
         d = GMin;
      end
      return 48'(d);
   endfunction

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   logic [1:0]         axis_ff, axis_in;
   point_entry_type    ent_ff, ent_in;
   logic signed [47:0] pend_ff [3][3];
   logic signed [47:0] pend_in [3][3];
   logic signed [47:0] pend_row [3];
   logic [62:0]        cost_ff, cost_in;
   logic [62:0]        tmp_ff, tmp_in, val_ff, val_in, inv4_ff, inv4_in, t_ff, t_in;
   logic [2:0]         emit_ff, emit_in;
   logic               axis_done;
   logic               valid_ff, valid_in;
   logic [9:0]         idx_ff, idx_in;
   logic signed [47:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic [62:0]        tc_ff, tc_in;
   logic               last_ff, last_in;
   axis_diff_type      ax;

   assign ax = ent_ff.axis[0];

   always_comb begin
      mul_req.start = (state_ff == S_ISSUE);
      case (step_ff)
         STEP_V_MM: begin
            mul_req.op_a = {32'b0, ax.vmag};
            mul_req.op_b = {32'b0, ax.vmag};
         end
         STEP_V_MI: begin
            mul_req.op_a = {1'b0, tmp_ff};
            mul_req.op_b = {32'b0, csr.inv_interval_sq};
         end
         STEP_V_LIM: begin
            mul_req.op_a = {32'b0, csr.max_speed};
            mul_req.op_b = {32'b0, csr.max_speed};
         end
         STEP_V_COST, STEP_A_COST: begin
            mul_req.op_a = {1'b0, val_ff};
            mul_req.op_b = {1'b0, val_ff};
         end
         STEP_V_T: begin
            mul_req.op_a = {1'b0, val_ff};
            mul_req.op_b = {32'b0, csr.inv_interval_sq};
         end
         STEP_V_G: begin
            mul_req.op_a = {1'b0, t_ff};
            mul_req.op_b = {32'b0, ax.vmag};
         end
         STEP_A_INV4: begin
            mul_req.op_a = {32'b0, csr.inv_interval_sq};
            mul_req.op_b = {32'b0, csr.inv_interval_sq};
         end
         STEP_A_MM: begin
            mul_req.op_a = {30'b0, ax.amag};
            mul_req.op_b = {30'b0, ax.amag};
         end
         STEP_A_MI: begin
            mul_req.op_a = {1'b0, tmp_ff};
            mul_req.op_b = {1'b0, inv4_ff};
         end
         STEP_A_LIM: begin
            mul_req.op_a = {32'b0, csr.max_accel};
            mul_req.op_b = {32'b0, csr.max_accel};
         end
         STEP_A_T: begin
            mul_req.op_a = {1'b0, val_ff};
            mul_req.op_b = {1'b0, inv4_ff};
         end
         STEP_A_G: begin
            mul_req.op_a = {1'b0, t_ff};
            mul_req.op_b = {30'b0, ax.amag};
         end
         default: begin
            mul_req.op_a = {1'b0, sat2(t_ff)};
            mul_req.op_b = {30'b0, ax.amag};
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      axis_in = axis_ff;
      ent_in = ent_ff;
      pend_in = pend_ff;
      cost_in = cost_ff;
      tmp_in = tmp_ff;
      val_in = val_ff;
      inv4_in = inv4_ff;
      t_in = t_ff;
      emit_in = emit_ff;
      valid_in = valid_ff;
      idx_in = idx_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      gz_in = gz_ff;
      tc_in = tc_ff;
      last_in = last_ff;
      q_pop = 1'b0;
      axis_done = 1'b0;
      pend_row = pend_ff[0];
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               ent_in = q_entry;
               axis_in = '0;
               for (int a = 0; a < 3; a++) begin
                  pend_in[a][0] = pend_ff[a][1];
                  pend_in[a][1] = pend_ff[a][2];
                  pend_in[a][2] = '0;
               end
               emit_in = {q_entry.fin, q_entry.fin && (q_entry.fill != 2'd0),
                          q_entry.fill == 2'd2};
               step_in = STEP_V_MM;
               state_in = (q_entry.fill != 2'd0) ? S_ISSUE : S_LOAD;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (mul_rsp.done) begin
               state_in = S_ISSUE;
               case (step_ff)
                  STEP_V_MM: begin
                     tmp_in = mul_rsp.prod;
                     step_in = STEP_V_MI;
                  end
                  STEP_V_MI: begin
                     tmp_in = mul_rsp.prod;
                     step_in = STEP_V_LIM;
                  end
                  STEP_V_LIM: begin
                     if (tmp_ff > mul_rsp.prod) begin
                        val_in = tmp_ff - mul_rsp.prod;
                        step_in = STEP_V_COST;
                     end else if (ent_ff.fill == 2'd2) begin
                        step_in = STEP_A_INV4;
                     end else begin
                        axis_done = 1'b1;
                     end
                  end
                  STEP_V_COST: begin
                     cost_in = add_cost(cost_ff, mul_rsp.prod);
                     step_in = STEP_V_T;
                  end
                  STEP_V_T: begin
                     t_in = sat4(mul_rsp.prod);
                     step_in = STEP_V_G;
                  end
                  STEP_V_G: begin
                     pend_in[0][1] = add_grad(pend_ff[0][1], !ax.vneg, mul_rsp.prod);
                     pend_in[0][2] = add_grad(pend_ff[0][2], ax.vneg, mul_rsp.prod);
                     if (ent_ff.fill == 2'd2) begin
                        step_in = STEP_A_INV4;
                     end else begin
                        axis_done = 1'b1;
                     end
                  end
                  STEP_A_INV4: begin
                     inv4_in = mul_rsp.prod;
                     step_in = STEP_A_MM;
                  end
                  STEP_A_MM: begin
                     tmp_in = mul_rsp.prod;
                     step_in = STEP_A_MI;
                  end
                  STEP_A_MI: begin
                     tmp_in = mul_rsp.prod;
                     step_in = STEP_A_LIM;
                  end
                  STEP_A_LIM: begin
                     if (tmp_ff > mul_rsp.prod) begin
                        val_in = tmp_ff - mul_rsp.prod;
                        step_in = STEP_A_COST;
                     end else begin
                        axis_done = 1'b1;
                     end
                  end
                  STEP_A_COST: begin
                     cost_in = add_cost(cost_ff, mul_rsp.prod);
                     step_in = STEP_A_T;
                  end
                  STEP_A_T: begin
                     t_in = sat4(mul_rsp.prod);
                     step_in = STEP_A_G;
                  end
                  STEP_A_G: begin
                     pend_in[0][0] = add_grad(pend_ff[0][0], ax.aneg, mul_rsp.prod);
                     pend_in[0][2] = add_grad(pend_ff[0][2], ax.aneg, mul_rsp.prod);
                     step_in = STEP_A_G2;
                  end
                  default: begin
                     pend_in[0][1] = add_grad(pend_ff[0][1], !ax.aneg, mul_rsp.prod);
                     axis_done = 1'b1;
                  end
               endcase
               if (axis_done) begin
                  pend_row = pend_in[0];
                  pend_in[0] = pend_in[1];
                  pend_in[1] = pend_in[2];
                  pend_in[2] = pend_row;
                  ent_in.axis = {ent_ff.axis[0], ent_ff.axis[2], ent_ff.axis[1]};
                  step_in = STEP_V_MM;
                  if (axis_ff == 2'd2) begin
                     state_in = S_LOAD;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
            end
         end
         S_LOAD: begin
            if (emit_ff[0]) begin
               emit_in[0] = 1'b0;
               idx_in = ent_ff.idx0;
               gx_in = pend_ff[0][0];
               gy_in = pend_ff[1][0];
               gz_in = pend_ff[2][0];
               tc_in = '0;
               last_in = 1'b0;
               valid_in = 1'b1;
               state_in = S_SEND;
            end else if (emit_ff[1]) begin
               emit_in[1] = 1'b0;
               idx_in = ent_ff.idx1;
               gx_in = pend_ff[0][1];
               gy_in = pend_ff[1][1];
               gz_in = pend_ff[2][1];
               tc_in = '0;
               last_in = 1'b0;
               valid_in = 1'b1;
               state_in = S_SEND;
            end else if (emit_ff[2]) begin
               emit_in[2] = 1'b0;
               idx_in = ent_ff.idx2;
               gx_in = pend_ff[0][2];
               gy_in = pend_ff[1][2];
               gz_in = pend_ff[2][2];
               tc_in = cost_ff;
               last_in = 1'b1;
               valid_in = 1'b1;
               state_in = S_SEND;
               for (int a = 0; a < 3; a++) begin
                  for (int s = 0; s < 3; s++) begin
                     pend_in[a][s] = '0;
                  end
               end
               cost_in = '0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SEND: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= STEP_V_MM;
         axis_ff <= '0;
         emit_ff <= '0;
         valid_ff <= 1'b0;
         cost_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < 3; s++) begin
               pend_ff[a][s] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         axis_ff <= axis_in;
         emit_ff <= emit_in;
         valid_ff <= valid_in;
         cost_ff <= cost_in;
         pend_ff <= pend_in;
      end
      ent_ff <= ent_in;
      tmp_ff <= tmp_in;
      val_ff <= val_in;
      inv4_ff <= inv4_in;
      t_ff <= t_in;
      idx_ff <= idx_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      gz_ff <= gz_in;
      tc_ff <= tc_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_point_index = idx_ff;
   assign rsp_grad_x = gx_ff;
   assign rsp_grad_y = gy_ff;
   assign rsp_grad_z = gz_ff;
   assign rsp_total_cost = tc_ff;
   assign rsp_last_result = last_ff;
endmodule
`default_nettype wire

// ===== src/kinematic_feasibility_cost_top.sv =====
// Top level of the kinematic feasibility cost block: registers, front end, queue, back end.
//
// Usage: control points arrive on the req_ channel (valid/stall), one word per point,
// with req_final_point set on the last point of a trajectory. Gradient words leave on
// the rsp_ channel: one per point, emitted once the point two places later has arrived;
// the final point flushes the last two and carries total_cost with last_result set.
// The csr_ port writes max_speed, max_accel and inv_interval_sq; the user must write them
// only while the block is idle, which the block itself does not enforce. A two-word queue
// lets the input side run ahead while the back end works or the receiver stalls; rsp_
// words hold steady under rsp_stall. One shared 32x32 multiplier runs each Q16.16
// product as four partial products; a point needs up to 14 products per axis (3 axes),
// and the back end finishes one point before it pops the next from the queue. rsp_valid
// and the rsp_ word are driven from registers.
// Reset (synchronous, active high) clears the trajectory, the queue and rsp_valid and
// loads inv_interval_sq with 1.0 and both limits with zero.
`default_nettype none
module kinematic_feasibility_cost_top #(
   parameter int unsigned MAX_POINTS = kfc_pkg::MaxPointsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_pos_x,
   input  logic signed [31:0]                  req_pos_y,
   input  logic signed [31:0]                  req_pos_z,
   input  logic                                req_final_point,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [9:0]                          rsp_point_index,
   output logic signed [47:0]                  rsp_grad_x,
   output logic signed [47:0]                  rsp_grad_y,
   output logic signed [47:0]                  rsp_grad_z,
   output logic [62:0]                         rsp_total_cost,
   output logic                                rsp_last_result,
   input  logic                                csr_wr_en,
   input  logic [kfc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [31:0]                         csr_wr_data
);
   import kfc_pkg::*;

   csr_type         csr_ff, csr_in;
   logic            push, full, pop, empty;
   point_entry_type push_entry, pop_entry;
   mul_req_type     mul_req;
   mul_rsp_type     mul_rsp;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_SPEED:       csr_in.max_speed = csr_wr_data;
            CSR_MAX_ACCEL:       csr_in.max_accel = csr_wr_data;
            CSR_INV_INTERVAL_SQ: csr_in.inv_interval_sq = csr_wr_data;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_speed <= '0;
         csr_ff.max_accel <= '0;
         csr_ff.inv_interval_sq <= InvIntervalSqReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   kfc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_final_point(req_final_point),
      .push(push),
      .push_entry(push_entry),
      .full(full)
   );

   kfc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(full),
      .pop(pop),
      .pop_entry(pop_entry),
      .empty(empty)
   );

   kfc_mul u_mul (
      .clock(clock),
      .reset(reset),
      .req(mul_req),
      .rsp(mul_rsp)
   );

   kfc_back u_back (
      .clock(clock),
      .reset(reset),
      .q_entry(pop_entry),
      .q_empty(empty),
      .q_pop(pop),
      .csr(csr_ff),
      .mul_req(mul_req),
      .mul_rsp(mul_rsp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point_index(rsp_point_index),
      .rsp_grad_x(rsp_grad_x),
      .rsp_grad_y(rsp_grad_y),
      .rsp_grad_z(rsp_grad_z),
      .rsp_total_cost(rsp_total_cost),
      .rsp_last_result(rsp_last_result)
   );
endmodule
`default_nettype wire

// ===== src/kfc_checker.sv =====
// Port-level checks of the kinematic feasibility cost block and their binding to the top level.
`default_nettype none
module kfc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic signed [31:0]                req_pos_x,
   input logic signed [31:0]                req_pos_y,
   input logic signed [31:0]                req_pos_z,
   input logic                              req_final_point,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [9:0]                        rsp_point_index,
   input logic signed [47:0]                rsp_grad_x,
   input logic signed [47:0]                rsp_grad_y,
   input logic signed [47:0]                rsp_grad_z,
   input logic [62:0]                       rsp_total_cost,
   input logic                              rsp_last_result,
   input logic                              csr_wr_en,
   input logic [kfc_pkg::CsrIndexWidth-1:0] csr_index,
   input logic [31:0]                       csr_wr_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_index)
         && $stable(rsp_grad_x) && $stable(rsp_last_result))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_cost_last_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_total_cost == 63'd0)
      else $error("cost shown on a word that is not the last");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_result |=> !rsp_valid)
      else $error("word follows the last word without a gap");
endmodule

bind kinematic_feasibility_cost_top kfc_checker u_kfc_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the kinematic feasibility cost block.
`timescale 1ns / 1ps
module tb;
   import kfc_pkg::*;

   localparam int unsigned NumPoints = 1024;
   localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint GradMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint GradMin = -64'sh0000_8000_0000_0000;
   localparam int unsigned IdleLimit = 20000;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic fin;
   } point_word_type;

   typedef struct {
      logic [9:0] idx;
      logic signed [47:0] gx;
      logic signed [47:0] gy;
      logic signed [47:0] gz;
      logic [62:0] cost;
      logic last;
   } grad_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic req_final_point = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [9:0] rsp_point_index;
   logic signed [47:0] rsp_grad_x;
   logic signed [47:0] rsp_grad_y;
   logic signed [47:0] rsp_grad_z;
   logic [62:0] rsp_total_cost;
   logic rsp_last_result;
   logic csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [31:0] csr_wr_data = '0;

   kinematic_feasibility_cost_top DUT (.*);

   always #4 clock = ~clock;

   point_word_type pending_points[$];
   grad_word_type expected_grads[$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned hold_off = 0;
   bit flood_req = 1'b0;

   logic [63:0] lim_speed, lim_accel, inv_sq;
   longint hist_x[2], hist_y[2], hist_z[2];
   longint acc_gx[3], acc_gy[3], acc_gz[3];
   int unsigned point_count, history_fill;
   logic [63:0] cost_total;

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      if (p[127:79] != '0) return SatMax;
      return {1'b0, p[78:16]};
   endfunction

   function automatic logic [63:0] fx_scale(logic [63:0] v, logic [63:0] k);
      if (v > SatMax / k) return SatMax;
      return v * k;
   endfunction

   function automatic void cost_add(logic [63:0] v);
      cost_total = (cost_total > SatMax - v) ? SatMax : cost_total + v;
   endfunction

   function automatic longint grad_add(longint g, bit neg, logic [63:0] mag);
      longint d;
      if (mag > 64'h1_0000_0000_0000) mag = 64'h1_0000_0000_0000;
      d = neg ? -longint'(mag) : longint'(mag);
      d += g;
      if (d > GradMax) d = GradMax;
      if (d < GradMin) d = GradMin;
      return d;
   endfunction

   task automatic penalize_axis(ref longint hist[2], ref longint acc[3], input longint cur);
      longint v, a;
      bit neg;
      logic [63:0] m, sq, lim, dv, t, g, inv4;
      if (history_fill >= 1) begin
         v = cur - hist[1];
         neg = v < 0;
         m = neg ? -v : v;
         sq = fx_mul(fx_mul(m, m), inv_sq);
         lim = fx_mul(lim_speed, lim_speed);
         if (sq > lim) begin
            dv = sq - lim;
            cost_add(fx_mul(dv, dv));
            g = fx_mul(fx_scale(fx_mul(dv, inv_sq), 4), m);
            acc[1] = grad_add(acc[1], !neg, g);
            acc[2] = grad_add(acc[2], neg, g);
         end
      end
      if (history_fill >= 2) begin
         a = cur - 2 * hist[1] + hist[0];
         neg = a < 0;
         m = neg ? -a : a;
         inv4 = fx_mul(inv_sq, inv_sq);
         sq = fx_mul(fx_mul(m, m), inv4);
         lim = fx_mul(lim_accel, lim_accel);
         if (sq > lim) begin
            dv = sq - lim;
            cost_add(fx_mul(dv, dv));
            t = fx_scale(fx_mul(dv, inv4), 4);
            g = fx_mul(t, m);
            acc[0] = grad_add(acc[0], neg, g);
            acc[1] = grad_add(acc[1], !neg, fx_mul(fx_scale(t, 2), m));
            acc[2] = grad_add(acc[2], neg, g);
         end
      end
      hist[0] = hist[1];
      hist[1] = cur;
   endtask

   function automatic void clear_trajectory();
      hist_x = '{0, 0}; hist_y = '{0, 0}; hist_z = '{0, 0};
      acc_gx = '{0, 0, 0}; acc_gy = '{0, 0, 0}; acc_gz = '{0, 0, 0};
      point_count = 0;
      history_fill = 0;
      cost_total = '0;
   endfunction

   function automatic void push_grad(int slot, int unsigned idx, bit last);
      grad_word_type w;
      w.idx = idx[9:0];
      w.gx = acc_gx[slot][47:0];
      w.gy = acc_gy[slot][47:0];
      w.gz = acc_gz[slot][47:0];
      w.cost = last ? cost_total[62:0] : '0;
      w.last = last;
      expected_grads = {expected_grads, w};
   endfunction

   task automatic predict_gradients(point_word_type p);
      int unsigned n;
      n = point_count % NumPoints;
      acc_gx = '{acc_gx[1], acc_gx[2], 0};
      acc_gy = '{acc_gy[1], acc_gy[2], 0};
      acc_gz = '{acc_gz[1], acc_gz[2], 0};
      penalize_axis(hist_x, acc_gx, longint'(p.x));
      penalize_axis(hist_y, acc_gy, longint'(p.y));
      penalize_axis(hist_z, acc_gz, longint'(p.z));
      if (history_fill >= 2) push_grad(0, (n + NumPoints - 2) % NumPoints, 1'b0);
      if (p.fin) begin
         if (history_fill >= 1) push_grad(1, (n + NumPoints - 1) % NumPoints, 1'b0);
         push_grad(2, n, 1'b1);
         clear_trajectory();
      end else begin
         if (history_fill < 2) history_fill++;
         point_count = (n + 1) % NumPoints;
      end
   endtask

   always @(posedge clock) begin
      bit taken;
      taken = req_valid && !req_stall;
      if (!reset) begin
         if (taken) begin
            predict_gradients(pending_points.pop_front());
            send_gap = $urandom_range(0, 8);
         end else if (send_gap != 0 && !req_valid) begin
            send_gap = send_gap - 1;
         end
         if (taken || !req_valid) begin
            if (pending_points.size() != 0 && (send_gap == 0 || flood_req)) begin
               req_valid <= 1'b1;
               req_pos_x <= pending_points[0].x;
               req_pos_y <= pending_points[0].y;
               req_pos_z <= pending_points[0].z;
               req_final_point <= pending_points[0].fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      grad_word_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_grads.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word idx %0d", rsp_point_index);
            end else begin
               e = expected_grads.pop_front();
               if (rsp_point_index !== e.idx || rsp_grad_x !== e.gx || rsp_grad_y !== e.gy
                     || rsp_grad_z !== e.gz || rsp_total_cost !== e.cost
                     || rsp_last_result !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                        e.idx, e.gx, e.gy, e.gz, e.cost, e.last, rsp_point_index,
                        rsp_grad_x, rsp_grad_y, rsp_grad_z, rsp_total_cost, rsp_last_result);
               end
            end
            recv_gap <= $urandom_range(0, 8);
         end
         if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_stall <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord(int unsigned mode);
      case (mode)
         0: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         1: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
      point_word_type p;
      p.x = x; p.y = y; p.z = z; p.fin = fin;
      pending_points = {pending_points, p};
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      lim_speed = (idx == CSR_MAX_SPEED) ? {32'h0, data} : lim_speed;
      lim_accel = (idx == CSR_MAX_ACCEL) ? {32'h0, data} : lim_accel;
      inv_sq = (idx == CSR_INV_INTERVAL_SQ) ? {32'h0, data} : inv_sq;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (pending_points.size() != 0 || expected_grads.size() != 0 || req_valid)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      int unsigned len, mode;
      lim_speed = '0;
      lim_accel = '0;
      inv_sq = {32'h0, InvIntervalSqReset};
      clear_trajectory();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
      queue_point(32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0);
      queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1);
      queue_point(32'h0, 32'h0, 32'h0, 1'b0);
      queue_point(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 1'b0);
      queue_point(32'h0001_0000, 32'h0003_0000, 32'h0, 1'b0);
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
      drain();

      write_reg(CSR_MAX_SPEED, 32'h0001_8000);
      write_reg(CSR_MAX_ACCEL, 32'h0000_C000);
      write_reg(CSR_INV_INTERVAL_SQ, 32'h0004_0000);
      write_reg(2'd3, $urandom);
      for (int i = 0; i < 6; i++) queue_point(rand_coord(0), rand_coord(0), rand_coord(0), i == 5);
      flood_req = 1'b1;
      hold_off = 600;
      for (int i = 0; i < 12; i++) queue_point(rand_coord(1), rand_coord(1), rand_coord(1), i == 11);
      while (hold_off != 0) @(posedge clock);
      flood_req = 1'b0;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MAX_SPEED, 32'hFFFF_FFFF);
               write_reg(CSR_MAX_ACCEL, 32'hFFFF_FFFF);
               write_reg(CSR_INV_INTERVAL_SQ, 32'hFFFF_FFFF);
            end
            1: begin
               write_reg(CSR_MAX_SPEED, 32'h0);
               write_reg(CSR_MAX_ACCEL, 32'h0);
               write_reg(CSR_INV_INTERVAL_SQ, 32'h0);
            end
            2: begin
               write_reg(CSR_MAX_SPEED, $urandom_range(0, 32'h0004_0000));
               write_reg(CSR_MAX_ACCEL, $urandom_range(0, 32'h0004_0000));
               write_reg(CSR_INV_INTERVAL_SQ, $urandom_range(32'h4000, 32'h0010_0000));
            end
            default: begin
               write_reg(CSR_MAX_SPEED, $urandom);
               write_reg(CSR_MAX_ACCEL, $urandom_range(0, 32'h0001_0000));
               write_reg(CSR_INV_INTERVAL_SQ, $urandom);
            end
         endcase
         for (int n = 0; n < 100; n += len) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
               queue_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == len - 1);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
